// File: rtl/ffpa_pkg.sv
`default_nettype none
package ffpa_pkg;

  localparam int NUM_PAGES   = 4096;
  localparam int MAX_EXTENTS = 64;
  localparam int PAGE_W      = $clog2(NUM_PAGES);
  localparam int CNT_W       = PAGE_W + 1;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int USED_W      = IDX_W + 1;
  localparam int SUM_W       = CNT_W + 1;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PAGE_W-1:0] base_page;
    logic [CNT_W-1:0]  page_count;
  } ffpa_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] alloc_base;
    logic [CNT_W-1:0]  free_total;
  } ffpa_res_t;

  typedef struct packed {
    logic [PAGE_W-1:0] base;
    logic [CNT_W-1:0]  len;
  } ffpa_ext_t;

  typedef struct packed {
    logic              drop;
    logic              found;
    logic [PAGE_W-1:0] cb;
    logic [CNT_W-1:0]  cl;
  } ffpa_scan_t;

endpackage
`default_nettype wire

// File: rtl/ffpa_ram.sv
`default_nettype none
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/ffpa_scan_unit.sv
`default_nettype none
module ffpa_scan_unit
  import ffpa_pkg::*;
(
  input  wire logic [1:0]        mode,
  input  wire logic [CNT_W-1:0]  need,
  input  wire logic              found,
  input  wire logic [PAGE_W-1:0] cb,
  input  wire logic [CNT_W-1:0]  cl,
  input  wire ffpa_ext_t         entry,
  output ffpa_scan_t             res
);

  logic [SUM_W-1:0] sum_c;
  logic [SUM_W-1:0] sum_e;

  always_comb begin
    sum_c = {2'b00, cb} + {1'b0, cl};
    sum_e = {2'b00, entry.base} + {1'b0, entry.len};
    res.drop  = 1'b0;
    res.found = found;
    res.cb    = cb;
    res.cl    = cl;
    if (mode == REQ_ALLOC) begin
      if (!found && entry.len >= need) begin
        res.drop  = 1'b1;
        res.found = 1'b1;
      end
    end else begin
      priority if (sum_c == {2'b00, entry.base}) begin
        res.drop  = 1'b1;
        res.found = 1'b1;
        res.cl    = cl + entry.len;
      end else if (sum_e == {2'b00, cb}) begin
        res.drop  = 1'b1;
        res.found = 1'b1;
        res.cb    = entry.base;
        res.cl    = cl + entry.len;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/first_fit_page_allocator_unit.sv
// An add makes one shift pass over the extent table; an allocate or a free first makes one scan pass over it
// and then, where an extent is to be inserted, one shift pass; each pass takes one table entry per cycle.
// One request is in progress at a time; busy stays high until its result strobe.
// The result is shown for one cycle on out_valid; the receiver cannot stall it.
// After reset all 4096 entries of the block-size memory are cleared, with busy high.
`default_nettype none
module first_fit_page_allocator_unit
  import ffpa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire ffpa_req_t in_req,
  output logic           out_valid,
  output ffpa_res_t      out_res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_BSCHK = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_POST  = 4'd4;
  localparam logic [3:0] S_INS0  = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_HEAD  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [USED_W-1:0] USED_MAX = USED_W'(MAX_EXTENTS);
  localparam logic [SUM_W-1:0]  PAGES_S  = SUM_W'(NUM_PAGES);

  logic [3:0]        state_r, state_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [PAGE_W-1:0] clr_r, clr_nxt;
  ffpa_req_t         req_r, req_nxt;
  logic [PAGE_W-1:0] cb_r, cb_nxt;
  logic [CNT_W-1:0]  cl_r, cl_nxt;
  logic              found_r, found_nxt;
  logic [PAGE_W-1:0] fb_r, fb_nxt;
  logic [CNT_W-1:0]  fl_r, fl_nxt;
  logic [USED_W-1:0] rd_r, rd_nxt;
  logic              rv_r, rv_nxt;
  logic [USED_W-1:0] wp_r, wp_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [PAGE_W-1:0] abase_r, abase_nxt;

  logic              t_we;
  logic [IDX_W-1:0]  t_waddr;
  logic [IDX_W-1:0]  t_raddr;
  ffpa_ext_t         t_wdata;
  ffpa_ext_t         t_rdata;
  logic              b_we;
  logic [PAGE_W-1:0] b_waddr;
  logic [CNT_W-1:0]  b_wdata;
  logic [CNT_W-1:0]  b_rdata;
  ffpa_scan_t        scan;
  logic [SUM_W-1:0]  add_end;
  logic [SUM_W-1:0]  add_tot;

  ffpa_ram #(.WIDTH($bits(ffpa_ext_t)), .DEPTH(MAX_EXTENTS)) u_tbl (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  ffpa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_PAGES)) u_bsz (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (in_req.base_page),
    .rdata (b_rdata)
  );

  ffpa_scan_unit u_scan (
    .mode  (req_r.req_type),
    .need  (req_r.page_count),
    .found (found_r),
    .cb    (cb_r),
    .cl    (cl_r),
    .entry (t_rdata),
    .res   (scan)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign add_end   = {2'b00, in_req.base_page} + {1'b0, in_req.page_count};
  assign add_tot   = {1'b0, total_r} + {1'b0, in_req.page_count};

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    total_nxt  = total_r;
    clr_nxt    = clr_r;
    req_nxt    = req_r;
    cb_nxt     = cb_r;
    cl_nxt     = cl_r;
    found_nxt  = found_r;
    fb_nxt     = fb_r;
    fl_nxt     = fl_r;
    rd_nxt     = rd_r;
    rv_nxt     = rv_r;
    wp_nxt     = wp_r;
    pidx_nxt   = pidx_r;
    status_nxt = status_r;
    abase_nxt  = abase_r;
    t_we       = 1'b0;
    t_waddr    = wp_r[IDX_W-1:0];
    t_wdata    = t_rdata;
    t_raddr    = rd_r[IDX_W-1:0];
    b_we       = 1'b0;
    b_waddr    = clr_r;
    b_wdata    = '0;

    unique case (state_r)
      S_CLEAR: begin
        b_we    = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_req;
          abase_nxt  = '0;
          status_nxt = ST_OK;
          rd_nxt     = '0;
          rv_nxt     = 1'b0;
          wp_nxt     = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_DONE;
          unique case (in_req.req_type)
            REQ_ADD: begin
              if (in_req.page_count == '0 || add_end > PAGES_S || add_tot > PAGES_S) begin
                status_nxt = ST_BAD;
              end else if (used_r >= USED_MAX) begin
                status_nxt = ST_FULL;
              end else begin
                cb_nxt    = in_req.base_page;
                cl_nxt    = in_req.page_count;
                total_nxt = add_tot[CNT_W-1:0];
                state_nxt = S_INS0;
              end
            end
            REQ_ALLOC: begin
              if (in_req.page_count == '0) begin
                status_nxt = ST_BAD;
              end else if (in_req.page_count > total_r) begin
                status_nxt = ST_NOSPACE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            REQ_FREE: begin
              state_nxt = S_BSCHK;
            end
            default: begin
              status_nxt = ST_BAD;
            end
          endcase
        end
      end
      S_BSCHK: begin
        if (b_rdata == '0) begin
          status_nxt = ST_BAD;
          state_nxt  = S_DONE;
        end else begin
          cb_nxt    = req_r.base_page;
          cl_nxt    = b_rdata;
          fl_nxt    = b_rdata;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_r < used_r) begin
          rd_nxt = rd_r + 1'b1;
          rv_nxt = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r) begin
          found_nxt = scan.found;
          cb_nxt    = scan.cb;
          cl_nxt    = scan.cl;
          if (scan.drop) begin
            if (req_r.req_type == REQ_ALLOC) begin
              fb_nxt = t_rdata.base;
              fl_nxt = t_rdata.len;
            end
          end else begin
            t_we   = 1'b1;
            wp_nxt = wp_r + 1'b1;
          end
        end else if (rd_r == used_r) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        state_nxt = S_DONE;
        if (req_r.req_type == REQ_ALLOC) begin
          if (!found_r) begin
            status_nxt = ST_NOSPACE;
          end else begin
            used_nxt  = wp_r;
            total_nxt = total_r - req_r.page_count;
            abase_nxt = fb_r;
            b_we      = 1'b1;
            b_waddr   = fb_r;
            b_wdata   = req_r.page_count;
            if (fl_r > req_r.page_count) begin
              cb_nxt    = fb_r + req_r.page_count[PAGE_W-1:0];
              cl_nxt    = fl_r - req_r.page_count;
              state_nxt = S_INS0;
            end
          end
        end else begin
          if (!found_r && used_r >= USED_MAX) begin
            status_nxt = ST_FULL;
          end else begin
            used_nxt  = wp_r;
            total_nxt = total_r + fl_r;
            b_we      = 1'b1;
            b_waddr   = req_r.base_page;
            b_wdata   = '0;
            state_nxt = S_INS0;
          end
        end
      end
      S_INS0: begin
        rv_nxt = 1'b0;
        if (used_r == '0) begin
          state_nxt = S_HEAD;
        end else begin
          rd_nxt    = used_r - 1'b1;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (rv_r) begin
          t_we    = 1'b1;
          t_waddr = pidx_r + 1'b1;
        end
        if (rd_r != '0) begin
          pidx_nxt = rd_r[IDX_W-1:0];
          rd_nxt   = rd_r - 1'b1;
          rv_nxt   = 1'b1;
        end else begin
          rv_nxt = 1'b0;
          if (!rv_r) begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        t_we      = 1'b1;
        t_waddr   = (used_r == '0) ? '0 : IDX_W'(1);
        t_wdata   = '{base: cb_r, len: cl_r};
        used_nxt  = used_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      used_r   <= '0;
      total_r  <= '0;
      clr_r    <= '0;
      rv_r     <= 1'b0;
      found_r  <= 1'b0;
      rd_r     <= '0;
      wp_r     <= '0;
      status_r <= ST_OK;
      abase_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      total_r  <= total_nxt;
      clr_r    <= clr_nxt;
      rv_r     <= rv_nxt;
      found_r  <= found_nxt;
      rd_r     <= rd_nxt;
      wp_r     <= wp_nxt;
      status_r <= status_nxt;
      abase_r  <= abase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    cb_r   <= cb_nxt;
    cl_r   <= cl_nxt;
    fb_r   <= fb_nxt;
    fl_r   <= fl_nxt;
    pidx_r <= pidx_nxt;
  end

  assign out_res = '{status: status_r, alloc_base: abase_r, free_total: total_r};

endmodule
`default_nettype wire

// File: rtl/ffpa_checker.sv
`default_nettype none
module ffpa_checker
  import ffpa_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire ffpa_req_t in_req,
  input wire logic      out_valid,
  input wire ffpa_res_t out_res
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request accepted but block not busy");

  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid) else $error("result strobe not followed by idle");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while idle");

  a_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status != ST_OK |-> out_res.alloc_base == '0)
    else $error("allocated base given on a failed request");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_res.free_total} <= (SUM_W)'(NUM_PAGES))
    else $error("free total beyond page count");

endmodule

bind first_fit_page_allocator_unit ffpa_checker u_ffpa_checker (.*);
`default_nettype wire
